[rtl/core/ptdp_pkg.sv]
// ptdp_pkg: shared types and constants of the pose tolerance dedup pool
// no dependencies; imported by every module of the block

package ptdp_pkg;

  localparam int POS_W = 32;
  localparam int HDG_W = 16;
  localparam int PTOL_W = 31;
  localparam int ATOL_W = 15;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 1;
  localparam int OIDX_W = 6;
  localparam int OCNT_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_TOL = 1'b1;

  localparam logic [PTOL_W-1:0] POS_TOL_RST = 31'd65536;
  localparam logic [ATOL_W-1:0] ANG_TOL_RST = 15'd1430;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [HDG_W-1:0] heading;
  } pose_t;

  typedef struct packed {
    logic  start;
    pose_t pose;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_t;

endpackage

[rtl/core/ptdp_front.sv]
// ptdp_front: input register that takes pose transfers and forms commands
// depends on ptdp_pkg; feeds ptdp_queue

module ptdp_front
  import ptdp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_start_of_set,
  input  logic [POS_W-1:0] in_pos_x,
  input  logic [POS_W-1:0] in_pos_y,
  input  logic [POS_W-1:0] in_pos_z,
  input  logic [HDG_W-1:0] in_heading,
  input  q_stat_t          q_stat,
  output logic             q_push,
  output cmd_t             q_push_data
);

  logic hold_vld_r, hold_vld_nxt;
  cmd_t hold_r, hold_nxt;
  logic accept;

  assign q_push      = hold_vld_r && !q_stat.full;
  assign in_stall    = hold_vld_r && q_stat.full;
  assign accept      = in_valid && !in_stall;
  assign q_push_data = hold_r;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    if (accept) begin
      hold_vld_nxt         = 1'b1;
      hold_nxt.start       = in_start_of_set;
      hold_nxt.pose.pos_x  = in_pos_x;
      hold_nxt.pose.pos_y  = in_pos_y;
      hold_nxt.pose.pos_z  = in_pos_z;
      hold_nxt.pose.heading = in_heading;
    end else if (q_push) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

[rtl/core/ptdp_queue.sv]
// ptdp_queue: two-entry command queue between front and scan engine
// depends on ptdp_pkg

module ptdp_queue
  import ptdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_data,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/ptdp_scan.sv]
// ptdp_scan: pool memory, pipelined tolerance scan, append and result register
// depends on ptdp_pkg; takes commands from ptdp_queue

module ptdp_scan
  import ptdp_pkg::*;
#(
  parameter int POOL_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  cmd_t                 q_head,
  input  q_stat_t              q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_is_distinct,
  output logic                 out_was_stored,
  output logic                 out_overflow,
  output logic [OIDX_W-1:0]    out_entry_index,
  output logic [OCNT_W-1:0]    out_pool_count
);

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  scan_state_t st_r, st_nxt;

  logic [PTOL_W-1:0] pos_tol_r, pos_tol_nxt;
  logic [ATOL_W-1:0] ang_tol_r, ang_tol_nxt;

  pose_t   mem [POOL_DEPTH];
  pose_t   rd_r;
  logic    mem_we;
  logic [IW-1:0] mem_wa;

  pose_t          cmd_r, cmd_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  iss_r, iss_nxt;
  logic           s1_vld_r, s1_vld_nxt;
  logic [IW-1:0]  s1_idx_r, s1_idx_nxt;
  logic           s2_vld_r, s2_vld_nxt;
  logic [IW-1:0]  s2_idx_r;
  logic           found_r, found_nxt;
  logic [IW-1:0]  mid_r, mid_nxt;

  logic signed [POS_W:0] dx_r, ex_r, dy_r, ey_r, dz_r, ez_r;
  logic signed [HDG_W:0] dh_r, eh_r;
  logic signed [POS_W:0] ax, bx, ay, by, az, bz, ptol_s;
  logic signed [HDG_W:0] ah, bh, atol_s;

  logic hit, issue, scan_empty, out_free;

  logic              out_valid_r, out_valid_nxt;
  logic              out_dist_r, out_dist_nxt;
  logic              out_stor_r, out_stor_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic [OIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [OCNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // sign-extended operands, one extra bit so differences never wrap
  assign ax = {cmd_r.pos_x[POS_W-1], cmd_r.pos_x};
  assign bx = {rd_r.pos_x[POS_W-1], rd_r.pos_x};
  assign ay = {cmd_r.pos_y[POS_W-1], cmd_r.pos_y};
  assign by = {rd_r.pos_y[POS_W-1], rd_r.pos_y};
  assign az = {cmd_r.pos_z[POS_W-1], cmd_r.pos_z};
  assign bz = {rd_r.pos_z[POS_W-1], rd_r.pos_z};
  assign ah = {cmd_r.heading[HDG_W-1], cmd_r.heading};
  assign bh = {rd_r.heading[HDG_W-1], rd_r.heading};
  assign ptol_s = {2'b00, pos_tol_r};
  assign atol_s = {2'b00, ang_tol_r};

  // |d| < tol is the same as d < tol and -d < tol
  assign hit = s2_vld_r &&
               (dx_r < ptol_s) && (ex_r < ptol_s) &&
               (dy_r < ptol_s) && (ey_r < ptol_s) &&
               (dz_r < ptol_s) && (ez_r < ptol_s) &&
               (dh_r < atol_s) && (eh_r < atol_s);

  assign issue      = (st_r == ST_SCAN) && (iss_r < count_r) && !hit;
  assign scan_empty = (iss_r >= count_r) && !s1_vld_r && !s2_vld_r;
  assign out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_is_distinct = out_dist_r;
  assign out_was_stored  = out_stor_r;
  assign out_overflow    = out_ovf_r;
  assign out_entry_index = out_idx_r;
  assign out_pool_count  = out_cnt_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty) st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || scan_empty) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    s1_vld_nxt    = issue;
    s1_idx_nxt    = iss_r[IW-1:0];
    s2_vld_nxt    = s1_vld_r && !hit;
    found_nxt     = found_r;
    mid_nxt       = mid_r;
    mem_we        = 1'b0;
    mem_wa        = count_r[IW-1:0];
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt  = out_dist_r;
    out_stor_nxt  = out_stor_r;
    out_ovf_nxt   = out_ovf_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    pos_tol_nxt   = pos_tol_r;
    ang_tol_nxt   = ang_tol_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_POS_TOL: pos_tol_nxt = cfg_wdata[PTOL_W-1:0];
        CFG_ANG_TOL: ang_tol_nxt = cfg_wdata[ATOL_W-1:0];
        default: ;
      endcase
    end

    case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head.pose;
          iss_nxt   = '0;
          found_nxt = 1'b0;
          if (q_head.start) count_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (issue) iss_nxt = iss_r + CW'(1);
        if (hit) begin
          found_nxt = 1'b1;
          mid_nxt   = s2_idx_r;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = 1'b0;
          out_stor_nxt  = 1'b0;
          out_ovf_nxt   = 1'b0;
          out_idx_nxt   = '0;
          out_cnt_nxt   = OCNT_W'(count_r);
          if (found_r) begin
            out_idx_nxt = OIDX_W'(mid_r);
          end else if (count_r < DEPTH_C) begin
            mem_we       = 1'b1;
            out_dist_nxt = 1'b1;
            out_stor_nxt = 1'b1;
            out_idx_nxt  = OIDX_W'(count_r);
            count_nxt    = count_r + CW'(1);
            out_cnt_nxt  = OCNT_W'(count_r + CW'(1));
          end else begin
            out_dist_nxt = 1'b1;
            out_ovf_nxt  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // pool storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= cmd_r;
    end
    rd_r <= mem[iss_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pos_tol_r   <= POS_TOL_RST;
      ang_tol_r   <= ANG_TOL_RST;
      count_r     <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pos_tol_r   <= pos_tol_nxt;
      ang_tol_r   <= ang_tol_nxt;
      count_r     <= count_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    iss_r      <= iss_nxt;
    s1_idx_r   <= s1_idx_nxt;
    s2_idx_r   <= s1_idx_r;
    mid_r      <= mid_nxt;
    dx_r       <= ax - bx;
    ex_r       <= bx - ax;
    dy_r       <= ay - by;
    ey_r       <= by - ay;
    dz_r       <= az - bz;
    ez_r       <= bz - az;
    dh_r       <= ah - bh;
    eh_r       <= bh - ah;
    out_dist_r <= out_dist_nxt;
    out_stor_r <= out_stor_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

endmodule

[rtl/core/pose_tolerance_dedup_pool.sv]
// pose_tolerance_dedup_pool: top level of the pose dedup pool
// depends on ptdp_pkg, ptdp_front, ptdp_queue and ptdp_scan
//
// Usage: one candidate pose per input transfer (in_valid high, in_stall low).
// in_start_of_set empties the pool before that pose is checked. Each pose
// gives exactly one result transfer on the out_ channel: distinct or not,
// stored or not, overflow, matching or written slot, and the pool count.
// Tolerances are written through cfg_we / cfg_index / cfg_wdata while idle.
// Path: the pose passes an input register and a two-entry queue, then
// the scan engine reads one pool entry per cycle from the pool memory
// through a three-stage read/subtract/compare pipe. A duplicate ends the
// scan early. Items are scanned one at a time: the scan engine takes no
// new pose from the queue until the last result is in the output register.
// Reset: pool empty, tolerances at their defaults, nothing pending.
// Pool contents are not cleared; only slots below the count are read.
// When out_stall is high the result holds; the scan engine waits with the
// next finished item, and the queue and input register keep taking poses
// until they fill, after which in_stall rises.

module pose_tolerance_dedup_pool
  import ptdp_pkg::*;
#(
  parameter int POOL_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_start_of_set,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [POS_W-1:0]     in_pos_z,
  input  logic [HDG_W-1:0]     in_heading,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_is_distinct,
  output logic                 out_was_stored,
  output logic                 out_overflow,
  output logic [OIDX_W-1:0]    out_entry_index,
  output logic [OCNT_W-1:0]    out_pool_count
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  cmd_t    q_push_data, q_head;

  ptdp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_of_set (in_start_of_set),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_heading      (in_heading),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_push_data     (q_push_data)
  );

  ptdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  ptdp_scan #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .q_head          (q_head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_distinct (out_is_distinct),
    .out_was_stored  (out_was_stored),
    .out_overflow    (out_overflow),
    .out_entry_index (out_entry_index),
    .out_pool_count  (out_pool_count)
  );

endmodule

[tb/sv/tb.sv]
// tb: self-checking bench for the pose tolerance dedup pool
// depends on ptdp_pkg and pose_tolerance_dedup_pool; keeps its own copy of the
// pool and tolerances to predict every result transfer

module tb;
  import ptdp_pkg::*;

  localparam int DEPTH = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;

  localparam logic [POS_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
  localparam logic [HDG_W-1:0] HDG_MAX = 16'h7fff;
  localparam logic [HDG_W-1:0] HDG_MIN = 16'h8000;

  typedef struct packed {
    logic              distinct;
    logic              stored;
    logic              ovf;
    logic [OIDX_W-1:0] slot;
    logic [OCNT_W-1:0] count;
  } verdict_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POS_TOL;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_start_of_set = 1'b0;
  logic [POS_W-1:0]     in_pos_x = '0;
  logic [POS_W-1:0]     in_pos_y = '0;
  logic [POS_W-1:0]     in_pos_z = '0;
  logic [HDG_W-1:0]     in_heading = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_is_distinct;
  logic                 out_was_stored;
  logic                 out_overflow;
  logic [OIDX_W-1:0]    out_entry_index;
  logic [OCNT_W-1:0]    out_pool_count;

  // predicted pool contents and tolerances
  logic [POS_W-1:0]  kept_x [DEPTH];
  logic [POS_W-1:0]  kept_y [DEPTH];
  logic [POS_W-1:0]  kept_z [DEPTH];
  logic [HDG_W-1:0]  kept_hdg [DEPTH];
  int unsigned       kept_count = 0;
  logic [PTOL_W-1:0] pos_tol = POS_TOL_RST;
  logic [ATOL_W-1:0] ang_tol = ANG_TOL_RST;

  verdict_t verdict_q[$];
  int       fail_count = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  bit       bursty = 1'b1;
  int       rx_span = 0;
  rx_mode_t rx_mode = RX_OPEN;

  initial forever #6 clk = ~clk;

  pose_tolerance_dedup_pool #(
    .POOL_DEPTH(DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_of_set (in_start_of_set),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_heading      (in_heading),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_distinct (out_is_distinct),
    .out_was_stored  (out_was_stored),
    .out_overflow    (out_overflow),
    .out_entry_index (out_entry_index),
    .out_pool_count  (out_pool_count)
  );

  // differences are taken at 64 bits so nothing wraps
  function automatic bit close_enough(longint a, longint b, longint tol);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d < tol;
  endfunction

  function automatic verdict_t judge_pose(logic sos, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                          logic [POS_W-1:0] z, logic [HDG_W-1:0] h);
    verdict_t v;
    bit       hit;
    v = '0;
    hit = 1'b0;
    if (sos) kept_count = 0;
    for (int i = 0; i < kept_count && !hit; i++) begin
      if (close_enough($signed(x), $signed(kept_x[i]), pos_tol) &&
          close_enough($signed(y), $signed(kept_y[i]), pos_tol) &&
          close_enough($signed(z), $signed(kept_z[i]), pos_tol) &&
          close_enough($signed(h), $signed(kept_hdg[i]), ang_tol)) begin
        hit = 1'b1;
        v.slot = OIDX_W'(i);
      end
    end
    if (!hit) begin
      v.distinct = 1'b1;
      if (kept_count < DEPTH) begin
        kept_x[kept_count] = x;
        kept_y[kept_count] = y;
        kept_z[kept_count] = z;
        kept_hdg[kept_count] = h;
        v.slot = OIDX_W'(kept_count);
        v.stored = 1'b1;
        kept_count++;
      end else begin
        v.ovf = 1'b1;
      end
    end
    v.count = OCNT_W'(kept_count);
    return v;
  endfunction

  // offset around a pooled value, often right at the tolerance edge
  function automatic longint nudge(longint base, longint tol);
    longint mag;
    case ($urandom_range(0, 7))
      0: mag = tol;
      1: mag = (tol > 0) ? tol - 1 : 0;
      2: mag = 0;
      default: mag = longint'($urandom_range(0, 32'(tol + tol / 4)));
    endcase
    return $urandom_range(0, 1) ? base + mag : base - mag;
  endfunction

  function automatic logic [POS_W-1:0] corner_pos();
    case ($urandom_range(0, 3))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic void make_pose(output logic [POS_W-1:0] x, output logic [POS_W-1:0] y,
                                    output logic [POS_W-1:0] z, output logic [HDG_W-1:0] h);
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 19);
    k = (kept_count > 0) ? $urandom_range(0, kept_count - 1) : 0;
    if (kept_count > 0 && sel < 11) begin
      x = POS_W'(nudge($signed(kept_x[k]), pos_tol));
      y = POS_W'(nudge($signed(kept_y[k]), pos_tol));
      z = POS_W'(nudge($signed(kept_z[k]), pos_tol));
      h = HDG_W'(nudge($signed(kept_hdg[k]), ang_tol));
    end else if (kept_count > 0 && sel < 13) begin
      x = kept_x[k];
      y = kept_y[k];
      z = kept_z[k];
      h = kept_hdg[k];
    end else if (sel < 15) begin
      x = corner_pos();
      y = corner_pos();
      z = corner_pos();
      h = HDG_W'(corner_pos() >> (POS_W - HDG_W));
    end else begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
      h = HDG_W'($urandom);
    end
  endfunction

  task automatic send_pose(input logic sos, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [POS_W-1:0] z, input logic [HDG_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = bursty ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_start_of_set <= sos;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_heading <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.insert(verdict_q.size(), judge_pose(sos, x, y, z, h));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_tolerances(input logic [PTOL_W-1:0] ptol, input logic [ATOL_W-1:0] atol);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_POS_TOL;
    cfg_wdata <= CFG_W'(ptol);
    @(posedge clk);
    pos_tol = ptol;
    cfg_index <= CFG_ANG_TOL;
    cfg_wdata <= CFG_W'(atol);
    @(posedge clk);
    ang_tol = atol;
    cfg_we <= 1'b0;
  endtask

  // boundaries of the tolerances, field extremes, no yaw wrap, first match wins
  task automatic test_edge_poses();
    send_pose(1'b1, '0, '0, '0, '0);
    send_pose(1'b0, '0, '0, '0, '0);
    send_pose(1'b0, 32'd65536, '0, '0, '0);
    send_pose(1'b0, 32'd65535, '0, '0, '0);
    send_pose(1'b0, '0, '0, '0, 16'd1430);
    send_pose(1'b0, '0, '0, POS_W'(-65535), HDG_W'(-1429));
    send_pose(1'b0, POS_MAX, POS_MAX, POS_MAX, HDG_MAX);
    send_pose(1'b0, POS_MIN, POS_MIN, POS_MIN, HDG_MIN);
    send_pose(1'b0, POS_MAX, POS_MAX, POS_MAX, HDG_MAX);
    send_pose(1'b1, POS_MIN, POS_MIN, POS_MIN, HDG_MIN);
    send_pose(1'b0, POS_MAX, POS_MAX, POS_MAX, HDG_MAX);
    set_tolerances('1, '1);
    send_pose(1'b1, POS_MIN, '0, '0, HDG_MIN);
    send_pose(1'b0, POS_MAX, '0, '0, HDG_MIN);
    send_pose(1'b0, '1, '0, '0, HDG_MIN);
    send_pose(1'b0, '0, '0, '0, HDG_MIN);
    send_pose(1'b0, '0, '0, '0, HDG_MAX);
    send_pose(1'b0, '0, '0, '0, '0);
    send_pose(1'b0, 32'd1, '0, '0, 16'd1);
    set_tolerances('0, '0);
    send_pose(1'b0, '0, '0, '0, '0);
  endtask

  // fill the pool with zero tolerance, then hit it full with a duplicate and a new pose
  task automatic test_pool_overflow();
    set_tolerances('0, '0);
    for (int n = 0; n < DEPTH + 3; n++) begin
      send_pose(n == 0, $urandom, $urandom, $urandom, HDG_W'($urandom));
    end
    set_tolerances(POS_TOL_RST, ANG_TOL_RST);
    send_pose(1'b0, kept_x[DEPTH / 2], kept_y[DEPTH / 2], kept_z[DEPTH / 2],
              kept_hdg[DEPTH / 2]);
    send_pose(1'b0, ~kept_x[0], ~kept_y[0], ~kept_z[0], ~kept_hdg[0]);
  endtask

  task automatic test_random_sets(input int items);
    int               sent;
    int               len;
    logic [POS_W-1:0] x, y, z;
    logic [HDG_W-1:0] h;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 3);
        1, 2: len = $urandom_range(60, 110);
        default: len = $urandom_range(4, 40);
      endcase
      bursty = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < len; n++) begin
        make_pose(x, y, z, h);
        // a stray start mid-set now and then
        send_pose(n == 0 || $urandom_range(0, 99) == 0, x, y, z, h);
      end
      sent += len;
      if ($urandom_range(0, 5) == 0) drain_results();
    end
  endtask

  task automatic test_tolerance_phases();
    set_tolerances(POS_TOL_RST, ANG_TOL_RST);
    test_random_sets(300);
    set_tolerances('1, '1);
    test_random_sets(150);
    set_tolerances('0, ANG_TOL_RST);
    test_random_sets(150);
    set_tolerances('1, '0);
    test_random_sets(150);
    for (int p = 0; p < 4; p++) begin
      set_tolerances(PTOL_W'($urandom_range(0, 32'h7fff_ffff) >> $urandom_range(0, 30)),
                     ATOL_W'($urandom_range(0, 32767) >> $urandom_range(0, 14)));
      test_random_sets(300);
    end
  endtask

  // receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_span = $urandom_range(8, 200);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    end
    rx_span--;
    case (rx_mode)
      RX_OPEN: out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (rx_span % 5 < 2);
    endcase
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_is_distinct, out_was_stored, out_overflow, out_entry_index, out_pool_count};
      if (verdict_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result transfer: distinct=%0b stored=%0b overflow=%0b index=%0d count=%0d",
                   got.distinct, got.stored, got.ovf, got.slot, got.count);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          if (fail_count < 10) begin
            $display("mismatch: expected distinct=%0b stored=%0b overflow=%0b index=%0d count=%0d",
                     want.distinct, want.stored, want.ovf, want.slot, want.count);
            $display("          actual   distinct=%0b stored=%0b overflow=%0b index=%0d count=%0d",
                     got.distinct, got.stored, got.ovf, got.slot, got.count);
          end
          fail_count++;
        end
      end
    end
  end

  // ends the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_poses();
    test_pool_overflow();
    test_tolerance_phases();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
